// ===== src/jsu_pkg.sv =====
// Shared types, codes and helpers for the JSON string unescaper.
package jsu_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_final;
  } in_item_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [7:0] out_byte;
    logic [2:0] error_cause;
    logic       run_last;
  } out_item_t;

  // One queued job: a single result, or a code point that expands to 1..3 UTF-8 bytes.
  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  cause;
    logic [15:0] value;
    logic [1:0]  count;
  } job_t;

  localparam int QDepth = 4;
  localparam int QAw    = $clog2(QDepth);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_STR  = 2'd1;
  localparam logic [1:0] PH_ESC  = 2'd2;
  localparam logic [1:0] PH_HEX  = 2'd3;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_NOQUOTE = 3'd1;
  localparam logic [2:0] ERR_CTRL    = 3'd2;
  localparam logic [2:0] ERR_ESC     = 3'd3;
  localparam logic [2:0] ERR_HEX     = 3'd4;
  localparam logic [2:0] ERR_SURR    = 3'd5;
  localparam logic [2:0] ERR_UNTERM  = 3'd6;

  localparam logic [15:0] SURR_LO   = 16'hd800;
  localparam logic [15:0] SURR_HI   = 16'hdfff;
  localparam logic [15:0] MAX_1BYTE = 16'h007f;
  localparam logic [15:0] MAX_2BYTE = 16'h07ff;
  localparam logic [7:0]  LEAD_2    = 8'hc0;
  localparam logic [7:0]  LEAD_3    = 8'he0;
  localparam logic [7:0]  CONT      = 8'h80;
  localparam logic [7:0]  CTRL_TOP  = 8'h20;

  // {valid, nibble}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= "0" && c <= "9") r = {1'b1, 4'(c - "0")};
    else if (c >= "a" && c <= "f") r = {1'b1, 4'(c - "a" + 8'd10)};
    else if (c >= "A" && c <= "F") r = {1'b1, 4'(c - "A" + 8'd10)};
    return r;
  endfunction

endpackage

// ===== src/jsu_front.sv =====
// Front end: parse state machine that turns each source byte into zero or one queued job.
module jsu_front import jsu_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     take,
  input  in_item_t item,
  output logic     push,
  output job_t     job
);

  logic [1:0]  phase, phase_next;
  logic [1:0]  hex_seen, hex_seen_next;
  logic [15:0] acc, acc_next;

  logic [7:0]  c;
  logic        fin;
  logic [4:0]  hx;
  logic [15:0] acc_new;
  logic [2:0]  ecause;
  logic        emit;
  logic [15:0] val;
  logic [1:0]  cnt;
  logic [1:0]  knd;

  always_comb begin
    c       = item.in_byte;
    fin     = item.is_final;
    hx      = hex_decode(c);
    acc_new = {acc[11:0], hx[3:0]};
    ecause  = ERR_NONE;
    emit    = 1'b0;
    val     = 16'd0;
    cnt     = 2'd1;
    knd     = KIND_DATA;
    phase_next    = phase;
    hex_seen_next = hex_seen;
    acc_next      = acc;
    case (phase)
      PH_IDLE: begin
        if (c == "\"") begin
          if (fin) ecause = ERR_UNTERM;
          else phase_next = PH_STR;
        end else if (c == " " || c == 8'h09 || c == 8'h0d || c == 8'h0a) begin
          if (fin) ecause = ERR_NOQUOTE;
        end else begin
          ecause = ERR_NOQUOTE;
        end
      end
      PH_STR: begin
        if (c == "\"") begin
          emit = 1'b1;
          knd  = KIND_DONE;
          phase_next = PH_IDLE;
        end else if (c < CTRL_TOP) begin
          ecause = ERR_CTRL;
        end else if (fin) begin
          ecause = ERR_UNTERM;
        end else if (c == "\\") begin
          phase_next = PH_ESC;
        end else begin
          emit = 1'b1;
          val  = {8'd0, c};
        end
      end
      PH_ESC: begin
        case (c)
          "\"":    val = {8'd0, c};
          "\\":    val = {8'd0, c};
          "/":     val = {8'd0, c};
          "b":     val = 16'h0008;
          "f":     val = 16'h000c;
          "n":     val = 16'h000a;
          "r":     val = 16'h000d;
          "t":     val = 16'h0009;
          "u":     val = 16'd0;
          default: ecause = ERR_ESC;
        endcase
        if (ecause == ERR_NONE) begin
          if (fin) begin
            ecause = ERR_UNTERM;
          end else if (c == "u") begin
            phase_next    = PH_HEX;
            hex_seen_next = 2'd0;
            acc_next      = 16'd0;
          end else begin
            phase_next = PH_STR;
            emit       = 1'b1;
          end
        end
      end
      default: begin
        if (!hx[4]) begin
          ecause = ERR_HEX;
        end else if (hex_seen == 2'd3) begin
          if (acc_new >= SURR_LO && acc_new <= SURR_HI) ecause = ERR_SURR;
          else if (fin) ecause = ERR_UNTERM;
          else begin
            phase_next    = PH_STR;
            hex_seen_next = 2'd0;
            acc_next      = 16'd0;
            emit = 1'b1;
            val  = acc_new;
            if (acc_new <= MAX_1BYTE) cnt = 2'd1;
            else if (acc_new <= MAX_2BYTE) cnt = 2'd2;
            else cnt = 2'd3;
          end
        end else if (fin) begin
          ecause = ERR_UNTERM;
        end else begin
          hex_seen_next = hex_seen + 2'd1;
          acc_next      = acc_new;
        end
      end
    endcase
    // any error wins over data and sends the parser back to idle
    if (ecause != ERR_NONE) begin
      emit = 1'b1;
      knd  = KIND_ERR;
      val  = 16'd0;
      cnt  = 2'd1;
      phase_next    = PH_IDLE;
      hex_seen_next = 2'd0;
      acc_next      = 16'd0;
    end else if (knd == KIND_DONE) begin
      hex_seen_next = 2'd0;
      acc_next      = 16'd0;
    end
    push      = take && emit;
    job.kind  = knd;
    job.cause = ecause;
    job.value = val;
    job.count = cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_IDLE;
      hex_seen <= 2'd0;
      acc      <= 16'd0;
    end else if (take) begin
      phase    <= phase_next;
      hex_seen <= hex_seen_next;
      acc      <= acc_next;
    end
  end

endmodule

// ===== src/jsu_queue.sv =====
// Small job FIFO between the parser and the UTF-8 emitter.
module jsu_queue import jsu_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t wr_job,
  input  logic pop,
  output logic full,
  output logic nonempty,
  output job_t head
);

  job_t             mem [QDepth];
  logic [QAw-1:0]   wr_ptr, rd_ptr;
  logic [QAw:0]     level;

  assign full     = (level == (QAw+1)'(QDepth));
  assign nonempty = (level != '0);
  assign head     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QAw'(1);
      if (pop)  rd_ptr <= rd_ptr + QAw'(1);
      case ({push, pop})
        2'b10:   level <= level + (QAw+1)'(1);
        2'b01:   level <= level - (QAw+1)'(1);
        default: level <= level;
      endcase
    end
  end

endmodule

// ===== src/jsu_back.sv =====
// Back end: expands queued jobs into output-register result beats, one per cycle unless stalled.
module jsu_back import jsu_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      nonempty,
  input  job_t      head,
  output logic      pop,
  output logic      res_valid,
  input  logic      res_stall,
  output out_item_t res_item
);

  logic [1:0] idx;
  logic       load;
  logic       last;
  logic [7:0] byte_val;

  assign load = nonempty && (!res_valid || !res_stall);
  assign last = (idx == head.count - 2'd1);
  assign pop  = load && last;

  always_comb begin
    case (head.count)
      2'd2: begin
        if (idx == 2'd0) byte_val = LEAD_2 | {3'd0, head.value[10:6]};
        else byte_val = CONT | {2'd0, head.value[5:0]};
      end
      2'd3: begin
        case (idx)
          2'd0:    byte_val = LEAD_3 | {4'd0, head.value[15:12]};
          2'd1:    byte_val = CONT | {2'd0, head.value[11:6]};
          default: byte_val = CONT | {2'd0, head.value[5:0]};
        endcase
      end
      default: byte_val = head.value[7:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      idx       <= 2'd0;
    end else begin
      if (load) begin
        res_valid <= 1'b1;
        idx       <= last ? 2'd0 : idx + 2'd1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_item.result_kind <= head.kind;
      res_item.out_byte    <= byte_val;
      res_item.error_cause <= head.cause;
      res_item.run_last    <= last;
    end
  end

endmodule

// ===== src/json_string_unescape_utf8_core.sv =====
// Top level: JSON string unescaper, source bytes in, UTF-8 string bytes and status out.
// A taken byte's job is written to the job queue; its beats then go to the output register.
// Throughput: one source byte per cycle unless the job queue is full; a \u escape emits up to
//   three beats from the emitter at one beat per cycle unless res_stall is high, with a
//   four-entry job queue absorbing the burst.
// Reset (rst, synchronous): parser idle awaiting a quote, queue empty, no result valid.
module json_string_unescape_utf8_core import jsu_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      src_valid,
  output logic      src_stall,
  input  in_item_t  src_item,
  output logic      res_valid,
  input  logic      res_stall,
  output out_item_t res_item
);

  logic take;
  logic push;
  logic pop;
  logic q_full;
  logic q_nonempty;
  job_t new_job;
  job_t head_job;

  // Parser stalls only when the job queue is full; it never waits on the output side directly.
  assign src_stall = q_full;
  assign take      = src_valid && !q_full;

  jsu_front u_front (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .item (src_item),
    .push (push),
    .job  (new_job)
  );

  jsu_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_job   (new_job),
    .pop      (pop),
    .full     (q_full),
    .nonempty (q_nonempty),
    .head     (head_job)
  );

  // Emitter: walks each job's beats and marks the final beat of the source byte.
  jsu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .nonempty  (q_nonempty),
    .head      (head_job),
    .pop       (pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
  );

endmodule

// ===== tb/sv/json_string_unescape_utf8_core_test.sv =====
// Self-checking testbench for the JSON string unescaper core with its own decode predictor.
module json_string_unescape_utf8_core_test;
  import jsu_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] QUOTE  = 8'h22;
  localparam logic [7:0] BSLASH = 8'h5c;

  logic      clk;
  logic      rst;
  logic      src_valid;
  logic      src_stall;
  in_item_t  src_item;
  logic      res_valid;
  logic      res_stall;
  out_item_t res_item;

  json_string_unescape_utf8_core uut (
    .clk      (clk),
    .rst      (rst),
    .src_valid(src_valid),
    .src_stall(src_stall),
    .src_item (src_item),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res_item (res_item)
  );

  // Source text waiting to go out, and result beats the decoder still owes us.
  in_item_t  src_text[$];
  out_item_t pending_beats[$];

  // Predictor copy of the decoder state.
  logic [1:0]  parse_phase;
  logic [1:0]  hex_count;
  logic [15:0] code_acc;

  // Idle control: per-beat random gaps on each side, plus a long sink hold.
  bit src_gaps_on  = 1'b1;
  bit sink_gaps_on = 1'b1;
  int sink_hold_left = 0;

  int bytes_sent     = 0;
  int beats_checked  = 0;
  int mismatches     = 0;
  int strings_closed = 0;
  int utf8_bursts    = 0;
  int cause_hits[8];

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Character helpers
  // ---------------------------------------------------------------------------

  // {valid, value} of a hex digit of either case.
  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b1, c[3:0]};
    // 'a'/'A' have low nibble 1, so adding 9 lands on 10..15
    if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) return {1'b1, c[3:0] + 4'd9};
    return 5'd0;
  endfunction

  // {valid, starts \u, decoded byte} for the letter after a backslash.
  function automatic logic [9:0] escape_map(input logic [7:0] c);
    case (c)
      QUOTE, BSLASH, 8'h2f: return {2'b10, c};
      "b": return {2'b10, 8'h08};
      "f": return {2'b10, 8'h0c};
      "n": return {2'b10, 8'h0a};
      "r": return {2'b10, 8'h0d};
      "t": return {2'b10, 8'h09};
      "u": return {2'b11, 8'h00};
      default: return 10'd0;
    endcase
  endfunction

  function automatic bit is_blank(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0d || c == 8'h0a;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
    if (n < 4'd10) return 8'h30 + {4'h0, n};
    return (upper ? 8'h37 : 8'h57) + {4'h0, n};
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 3))
      0: return 8'h20;
      1: return 8'h09;
      2: return 8'h0d;
      default: return 8'h0a;
    endcase
  endfunction

  function automatic logic [7:0] simple_escape_char();
    case ($urandom_range(0, 7))
      0: return QUOTE;
      1: return BSLASH;
      2: return 8'h2f;
      3: return "b";
      4: return "f";
      5: return "n";
      6: return "r";
      default: return "t";
    endcase
  endfunction

  // Any non-control byte but quote and backslash, which passes straight through a string.
  function automatic logic [7:0] plain_char();
    logic [7:0] b;
    do b = 8'($urandom_range(8'h20, 8'hff)); while (b == QUOTE || b == BSLASH);
    return b;
  endfunction

  function automatic logic [7:0] bad_escape_char();
    logic [7:0] b;
    logic [9:0] m;
    do begin
      b = 8'($urandom_range(0, 255));
      m = escape_map(b);
    end while (m[9]);
    return b;
  endfunction

  function automatic logic [7:0] non_hex_char();
    logic [7:0] b;
    logic [4:0] m;
    do begin
      b = 8'($urandom_range(0, 255));
      m = nibble_of(b);
    end while (m[4]);
    return b;
  endfunction

  // Code point outside the surrogate range, spread over 1-, 2- and 3-byte encodings.
  function automatic logic [15:0] random_code_point();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, MAX_1BYTE));
      1: return 16'($urandom_range(MAX_1BYTE + 1, MAX_2BYTE));
      2: return 16'($urandom_range(MAX_2BYTE + 1, SURR_LO - 1));
      default: return 16'($urandom_range(SURR_HI + 1, 16'hffff));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Decode predictor
  // ---------------------------------------------------------------------------

  function automatic out_item_t make_beat(input logic [1:0] kind, input logic [7:0] b,
                                          input logic [2:0] cause);
    out_item_t r;
    r.result_kind = kind;
    r.out_byte    = b;
    r.error_cause = cause;
    r.run_last    = 1'b0;
    return r;
  endfunction

  function automatic void go_idle();
    parse_phase = PH_IDLE;
    hex_count   = 2'd0;
    code_acc    = 16'd0;
  endfunction

  function automatic out_item_t error_beat(input logic [2:0] cause);
    go_idle();
    cause_hits[cause]++;
    return make_beat(KIND_ERR, 8'h00, cause);
  endfunction

  // Advance the predicted decoder by one source byte; queue what it should emit.
  task automatic unescape_byte(input logic [7:0] c, input logic fin);
    out_item_t   beats[$];
    logic [9:0]  esc;
    logic [4:0]  nib;
    logic [15:0] cp;
    case (parse_phase)
      PH_IDLE: begin
        if (c == QUOTE) begin
          // a quote on the last byte opens a string that can never close
          if (fin) beats = {beats, error_beat(ERR_UNTERM)};
          else parse_phase = PH_STR;
        end else if (!is_blank(c) || fin) begin
          beats = {beats, error_beat(ERR_NOQUOTE)};
        end
      end
      PH_STR: begin
        if (c == QUOTE) begin
          go_idle();
          strings_closed++;
          beats = {beats, make_beat(KIND_DONE, 8'h00, ERR_NONE)};
        end else if (c < CTRL_TOP) begin
          beats = {beats, error_beat(ERR_CTRL)};
        end else if (fin) begin
          // end of input wins over the data byte
          beats = {beats, error_beat(ERR_UNTERM)};
        end else if (c == BSLASH) begin
          parse_phase = PH_ESC;
        end else begin
          beats = {beats, make_beat(KIND_DATA, c, ERR_NONE)};
        end
      end
      PH_ESC: begin
        esc = escape_map(c);
        if (!esc[9]) beats = {beats, error_beat(ERR_ESC)};
        else if (fin) beats = {beats, error_beat(ERR_UNTERM)};
        else if (esc[8]) begin
          parse_phase = PH_HEX;
          hex_count   = 2'd0;
          code_acc    = 16'd0;
        end else begin
          parse_phase = PH_STR;
          beats = {beats, make_beat(KIND_DATA, esc[7:0], ERR_NONE)};
        end
      end
      default: begin
        nib = nibble_of(c);
        if (!nib[4]) begin
          beats = {beats, error_beat(ERR_HEX)};
        end else begin
          cp       = {code_acc[11:0], nib[3:0]};
          code_acc = cp;
          if (hex_count == 2'd3) begin
            // surrogate check comes before the end-of-input check
            if (cp >= SURR_LO && cp <= SURR_HI) beats = {beats, error_beat(ERR_SURR)};
            else if (fin) beats = {beats, error_beat(ERR_UNTERM)};
            else begin
              go_idle();
              parse_phase = PH_STR;
              utf8_bursts++;
              if (cp <= MAX_1BYTE) begin
                beats = {beats, make_beat(KIND_DATA, cp[7:0], ERR_NONE)};
              end else if (cp <= MAX_2BYTE) begin
                beats = {beats, make_beat(KIND_DATA, LEAD_2 | {3'b000, cp[10:6]}, ERR_NONE)};
                beats = {beats, make_beat(KIND_DATA, CONT | {2'b00, cp[5:0]}, ERR_NONE)};
              end else begin
                beats = {beats, make_beat(KIND_DATA, LEAD_3 | {4'h0, cp[15:12]}, ERR_NONE)};
                beats = {beats, make_beat(KIND_DATA, CONT | {2'b00, cp[11:6]}, ERR_NONE)};
                beats = {beats, make_beat(KIND_DATA, CONT | {2'b00, cp[5:0]}, ERR_NONE)};
              end
            end
          end else if (fin) begin
            beats = {beats, error_beat(ERR_UNTERM)};
          end else begin
            hex_count = hex_count + 2'd1;
          end
        end
      end
    endcase
    // last beat of this source byte carries run_last
    if (beats.size() > 0) beats[beats.size() - 1].run_last = 1'b1;
    pending_beats = {pending_beats, beats};
  endtask

  // ---------------------------------------------------------------------------
  // Source side
  // ---------------------------------------------------------------------------

  function automatic void add_byte(input logic [7:0] b);
    in_item_t it;
    it.in_byte  = b;
    it.is_final = 1'b0;
    src_text = {src_text, it};
  endfunction

  function automatic void add_str(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  function automatic void mark_final();
    src_text[src_text.size() - 1].is_final = 1'b1;
  endfunction

  function automatic void add_unicode(input logic [15:0] cp);
    add_byte(BSLASH);
    add_byte("u");
    add_byte(hex_char(cp[15:12], 1'($urandom_range(0, 1))));
    add_byte(hex_char(cp[11:8],  1'($urandom_range(0, 1))));
    add_byte(hex_char(cp[7:4],   1'($urandom_range(0, 1))));
    add_byte(hex_char(cp[3:0],   1'($urandom_range(0, 1))));
  endfunction

  function automatic void add_good_element();
    case ($urandom_range(0, 2))
      0: add_byte(plain_char());
      1: begin
        add_byte(BSLASH);
        add_byte(simple_escape_char());
      end
      default: add_unicode(random_code_point());
    endcase
  endfunction

  // Optional leading blanks, a quoted body, closing quote. A broken string swaps
  // one body element for a fault; the rest of it then runs on as stray text.
  function automatic void build_string(input bit broken);
    int n_elems;
    int bad_at;
    int start;
    n_elems = broken ? $urandom_range(1, 8) : $urandom_range(0, 8);
    bad_at  = broken ? $urandom_range(0, n_elems - 1) : -1;
    repeat ($urandom_range(0, 2)) add_byte(blank_char());
    add_byte(QUOTE);
    for (int i = 0; i < n_elems; i++) begin
      if (i != bad_at) begin
        add_good_element();
      end else begin
        case ($urandom_range(0, 4))
          0: begin
            // input ends somewhere inside an otherwise valid element
            start = src_text.size();
            add_good_element();
            src_text[$urandom_range(start, src_text.size() - 1)].is_final = 1'b1;
          end
          1: add_byte(8'($urandom_range(0, 8'h1f)));
          2: begin
            add_byte(BSLASH);
            add_byte(bad_escape_char());
          end
          3: begin
            add_byte(BSLASH);
            add_byte("u");
            repeat ($urandom_range(0, 3)) add_byte(hex_char(4'($urandom_range(0, 15)),
                                                            1'($urandom_range(0, 1))));
            add_byte(non_hex_char());
          end
          default: add_unicode(16'($urandom_range(SURR_LO, SURR_HI)));
        endcase
      end
    end
    add_byte(QUOTE);
    if ($urandom_range(0, 3) == 0) mark_final();
  endfunction

  function automatic void add_noise();
    repeat ($urandom_range(1, 4)) begin
      add_byte(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 3) == 0) mark_final();
    end
  endfunction

  // One source beat. Valid stays high between back-to-back beats; it only drops
  // for a drawn gap, so it is never lowered and raised in the same step.
  task automatic send_byte(input in_item_t it);
    int gap;
    gap = src_gaps_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      src_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    src_valid <= 1'b1;
    src_item  <= it;
    @(posedge clk);
    while (src_stall) @(posedge clk);
    unescape_byte(it.in_byte, it.is_final);
    bytes_sent++;
  endtask

  task automatic send_text();
    in_item_t it;
    while (src_text.size() > 0) begin
      it = src_text.pop_front();
      send_byte(it);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: stall generation and checking
  // ---------------------------------------------------------------------------

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_beat(input out_item_t got);
    out_item_t want;
    if (pending_beats.size() == 0) begin
      $error("result beat with nothing expected: kind %0d byte %0h cause %0d last %0d",
             got.result_kind, got.out_byte, got.error_cause, got.run_last);
      mismatches++;
      return;
    end
    want = pending_beats.pop_front();
    beats_checked++;
    check_field("result_kind", 8'(want.result_kind), 8'(got.result_kind));
    check_field("out_byte",    want.out_byte,        got.out_byte);
    check_field("error_cause", 8'(want.error_cause), 8'(got.error_cause));
    check_field("run_last",    8'(want.run_last),    8'(got.run_last));
  endtask

  // Beats are taken at the edge with the pre-edge stall; a random stall gap is drawn
  // after each beat, and a long hold from the pressure test overrides it.
  initial begin : result_sink
    int   hold;
    logic stall_next;
    hold = 0;
    res_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_valid && !res_stall) begin
        check_beat(res_item);
        hold = sink_gaps_on ? $urandom_range(0, 4) : 0;
      end
      if (sink_hold_left > 0) begin
        sink_hold_left--;
        stall_next = 1'b1;
      end else if (hold > 0) begin
        hold--;
        stall_next = 1'b1;
      end else begin
        stall_next = 1'b0;
      end
      res_stall <= stall_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Byte extremes, two- and three-byte UTF-8 at their upper bounds, and every error path.
  task automatic test_directed();
    // non-blank, non-quote byte while idle
    add_byte(8'h00);
    // blank as the last byte: nothing was ever opened
    add_byte(8'h20);
    mark_final();
    // opening quote as the last byte
    add_byte(QUOTE);
    mark_final();
    // skipped tab, top byte value, \u07Ff (two bytes), \uFFFF (three bytes),
    // closing quote on the last byte completes cleanly
    add_byte(8'h09);
    add_byte(QUOTE);
    add_byte(8'hff);
    add_str("\\u07Ff\\uFFFF\"");
    mark_final();
    // raw control byte inside a string
    add_byte(QUOTE);
    add_byte(8'h1f);
    // unknown escape on the last byte: the escape fault is reported, not end of input
    add_str("\"\\x");
    mark_final();
    // surrogate code point
    add_str("\"\\uDfFf");
    // non-hex digit in a \u escape
    add_str("\"\\u0g");
    // ordinary byte as the last byte: the data byte is dropped
    add_str("\"z");
    mark_final();
    send_text();
  endtask

  // Mostly well-formed strings with random content, some broken ones, some noise.
  task automatic test_random_text(input int byte_goal);
    int pick;
    while (bytes_sent < byte_goal) begin
      if ($urandom_range(0, 7) == 0) src_gaps_on  = !src_gaps_on;
      if ($urandom_range(0, 7) == 0) sink_gaps_on = !sink_gaps_on;
      pick = $urandom_range(0, 9);
      if (pick < 7) build_string(1'b0);
      else if (pick < 9) build_string(1'b1);
      else add_noise();
      send_text();
    end
    src_gaps_on  = 1'b1;
    sink_gaps_on = 1'b1;
  endtask

  // Sink holds off while the source streams three-byte escapes at full rate,
  // so the job queue fills and the input must stall.
  task automatic test_backpressure();
    src_gaps_on    = 1'b0;
    sink_gaps_on   = 1'b0;
    sink_hold_left = 60;
    repeat (2) begin
      add_byte(QUOTE);
      repeat (4) add_unicode(16'($urandom_range(SURR_HI + 1, 16'hffff)));
      add_byte(QUOTE);
    end
    send_text();
    src_gaps_on  = 1'b1;
    sink_gaps_on = 1'b1;
  endtask

  initial begin
    int waited;
    rst       <= 1'b1;
    src_valid <= 1'b0;
    src_item  <= '0;
    go_idle();
    foreach (cause_hits[i]) cause_hits[i] = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_text(380);
    test_backpressure();

    src_valid <= 1'b0;
    waited = 0;
    while (pending_beats.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    // an extra wait catches any stray beats
    repeat (10) @(posedge clk);
    if (pending_beats.size() != 0) begin
      $error("%0d expected result beats never arrived", pending_beats.size());
      mismatches++;
    end

    $display("Sent %0d source bytes, checked %0d result beats, %0d strings closed, %0d \\u decodes.",
             bytes_sent, beats_checked, strings_closed, utf8_bursts);
    $display("Faults by cause: quote %0d, control %0d, escape %0d, hex %0d, surrogate %0d, end %0d.",
             cause_hits[ERR_NOQUOTE], cause_hits[ERR_CTRL], cause_hits[ERR_ESC],
             cause_hits[ERR_HEX], cause_hits[ERR_SURR], cause_hits[ERR_UNTERM]);
    if (mismatches == 0) begin
      $display("json_string_unescape_utf8_core test passed");
    end else begin
      $display("json_string_unescape_utf8_core test failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("json_string_unescape_utf8_core test failed");
    $finish;
  end

endmodule

// ===== sim.f =====
src/jsu_pkg.sv
src/jsu_front.sv
src/jsu_queue.sv
src/jsu_back.sv
src/json_string_unescape_utf8_core.sv
tb/sv/json_string_unescape_utf8_core_test.sv
